>>> rtl/rolling_zscore_anomaly_detector_macros.svh
// Assertion macros used by the checker file of the z-score detector.
`ifndef ROLLING_ZSCORE_ANOMALY_DETECTOR_MACROS_SVH
`define ROLLING_ZSCORE_ANOMALY_DETECTOR_MACROS_SVH

// Checked only outside reset.
`define RZAD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rzad check failed");

// Checked at every edge, reset included.
`define RZAD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rzad check failed");

`endif

>>> rtl/rzad_pkg.sv
// Shared constants of the rolling z-score detector.
`default_nettype none
package rzad_pkg;

  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 104;
  localparam int PADDR_W   = 5;

  localparam logic [2:0] REG_WARMUP_LENGTH = 3'd0;
  localparam logic [2:0] REG_MIN_STD_DEV   = 3'd1;
  localparam logic [2:0] REG_MIN_ABS_DELTA = 3'd2;
  localparam logic [2:0] REG_WARNING_Z     = 3'd3;
  localparam logic [2:0] REG_CRITICAL_Z    = 3'd4;

  localparam logic [6:0]  RST_WARMUP_LENGTH = 7'd16;
  localparam logic [30:0] RST_MIN_STD_DEV   = 31'd65536;
  localparam logic [30:0] RST_MIN_ABS_DELTA = 31'd0;
  localparam logic [15:0] RST_WARNING_Z     = 16'd768;
  localparam logic [15:0] RST_CRITICAL_Z    = 16'd1280;

  // z quotient width: 33-bit gap shifted by 12
  localparam int ZW = 45;

endpackage
`default_nettype wire

>>> rtl/rolling_zscore_anomaly_detector.sv
// Rolling-window z-score anomaly detector, sequenced over one shared divider.
//
//  channel  | dir | handshake               | payload
//  s_*      | in  | s_tvalid / s_tready     | s_tdata: sample_value, stamp_in
//  m_*      | out | m_tvalid / m_tready     | m_tdata, m_tuser: event_severity
//  apb      | in  | psel, penable, pready=1 | paddr, pwdata, prdata
//
// A warmup request only stores its sample; an evaluated one makes two read
// passes over the window memory, up to three runs of the bit-serial divider
// (mean, variance, z) and a 32-step root.
// s_tready is high only when the sequencer is idle. A finished event waits in
// the output register; the next request is taken meanwhile and only its own
// result stalls on a full output. Reset is synchronous; the window memory has
// no reset, the fill count covers it.
`default_nettype none
module rolling_zscore_anomaly_detector #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rzad_pkg::S_TDATA_W-1:0]   s_tdata,   // sample_value[31:0], stamp_in[79:32]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [rzad_pkg::M_TDATA_W-1:0]   m_tdata,   // event_value[31:0], z_score[55:32], stamp_out[103:56]
  output logic                             m_tuser,   // event_severity[0]
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rzad_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int AW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW  = $clog2(WINDOW_MAX + 1);
  localparam int SW  = 32 + CW;
  localparam int DW  = 64 + CW;
  localparam int DCW = $clog2(DW + 1);
  localparam int ZW  = rzad_pkg::ZW;

  typedef enum logic [3:0] {
    S_IDLE, S_GAP, S_SUM, S_MEAN, S_SQ, S_VAR, S_SQRT, S_ZDIV, S_EVAL, S_OUT
  } state_t;

  state_t state;

  logic [6:0]  warmup_length;
  logic [30:0] min_std_dev;
  logic [30:0] min_abs_delta;
  logic [15:0] warning_z;
  logic [15:0] critical_z;

  logic [CW-1:0] fill_count;
  logic [AW-1:0] oldest_pointer;
  logic [CW-1:0] len;
  logic [CW-1:0] cnt;

  logic [31:0] x;
  logic [47:0] stamp;
  logic [SW-1:0] sum;
  logic          sum_neg;
  logic [31:0] mean;
  logic [31:0] ad;
  logic [63:0] sq;
  logic [DW-1:0] acc;
  logic p1, p2, p3;

  // shared divider
  logic [DW-1:0]  div_n;
  logic [31:0]    div_d;
  logic [31:0]    div_r;
  logic [DCW-1:0] div_cnt;
  logic [32:0]    div_r2;
  logic [32:0]    div_sub;
  logic           div_ge;

  // square root
  logic [63:0] sq_src;
  logic [34:0] sq_rem;
  logic [31:0] sq_root;
  logic [5:0]  sq_cnt;
  logic [34:0] sq_remn;
  logic [34:0] sq_trial;

  logic [ZW-1:0] zmag;
  logic          emit;
  logic          ev_sev;
  logic [23:0]   ev_z;

  logic [31:0] mem [WINDOW_MAX];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [31:0]   rdata;
  logic          issue;

  logic        o_sev;
  logic [31:0] o_val;
  logic [23:0] o_z;
  logic [47:0] o_stamp;

  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic        accept;
  logic        out_go;

  logic [32:0] dx;
  logic [31:0] ad_n;
  logic [63:0] sq_n;
  logic [32:0] dlt;
  logic [32:0] mag;
  logic        far, crit, warn;
  logic [ZW-1:0] zsat;
  logic [23:0]   zraw;
  logic [63:0]   var_sat;

  assign pready   = 1'b1;
  assign cfg_idx  = paddr[4:2];
  assign cfg_we   = psel & penable & pwrite;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign out_go   = (state == S_OUT) && !(emit && m_tvalid && !m_tready);
  assign issue    = (cnt < len);
  assign m_tdata  = {o_stamp, o_z, o_val};
  assign m_tuser  = o_sev;

  always_comb begin
    if (32'(warmup_length) > 32'(WINDOW_MAX)) begin
      len = CW'(WINDOW_MAX);
    end else if (warmup_length < 7'd2) begin
      len = CW'(2);
    end else begin
      len = CW'(warmup_length);
    end
  end

  always_comb begin
    case (cfg_idx)
      rzad_pkg::REG_WARMUP_LENGTH: prdata = {25'd0, warmup_length};
      rzad_pkg::REG_MIN_STD_DEV:   prdata = {1'b0, min_std_dev};
      rzad_pkg::REG_MIN_ABS_DELTA: prdata = {1'b0, min_abs_delta};
      rzad_pkg::REG_WARNING_Z:     prdata = {16'd0, warning_z};
      rzad_pkg::REG_CRITICAL_Z:    prdata = {16'd0, critical_z};
      default:                     prdata = 32'd0;
    endcase
  end

  assign div_r2  = {div_r, div_n[DW-1]};
  assign div_sub = div_r2 - {1'b0, div_d};
  assign div_ge  = (div_r2 >= {1'b0, div_d});

  assign sq_remn  = {sq_rem[32:0], sq_src[63:62]};
  assign sq_trial = {1'b0, sq_root, 2'b01};

  assign dx   = {rdata[31], rdata} - {mean[31], mean};
  assign ad_n = dx[32] ? (~dx[31:0] + 32'd1) : dx[31:0];
  assign sq_n = ad * ad;

  assign dlt = {x[31], x} - {mean[31], mean};
  assign mag = dlt[32] ? (~dlt + 33'd1) : dlt;

  assign var_sat = (|div_n[DW-1:64]) ? '1 : div_n[63:0];

  assign far  = (mag >= {2'b00, min_abs_delta});
  assign crit = far && (zmag >= {{(ZW-20){1'b0}}, critical_z, 4'd0});
  assign warn = far && (zmag >= {{(ZW-20){1'b0}}, warning_z, 4'd0});

  always_comb begin
    if (dlt[32]) begin
      zsat = (zmag > ZW'(24'h800000)) ? ZW'(24'h800000) : zmag;
      zraw = 24'd0 - zsat[23:0];
    end else begin
      zsat = (zmag > ZW'(24'h7FFFFF)) ? ZW'(24'h7FFFFF) : zmag;
      zraw = zsat[23:0];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = oldest_pointer;
    mem_wdata = x;
    if (accept && (fill_count < len)) begin
      mem_we    = 1'b1;
      mem_waddr = fill_count[AW-1:0];
      mem_wdata = s_tdata[31:0];
    end else if (out_go) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[cnt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      fill_count     <= '0;
      oldest_pointer <= '0;
      m_tvalid       <= 1'b0;
      warmup_length  <= rzad_pkg::RST_WARMUP_LENGTH;
      min_std_dev    <= rzad_pkg::RST_MIN_STD_DEV;
      min_abs_delta  <= rzad_pkg::RST_MIN_ABS_DELTA;
      warning_z      <= rzad_pkg::RST_WARNING_Z;
      critical_z     <= rzad_pkg::RST_CRITICAL_Z;
    end else begin
      if (m_tvalid && m_tready && !(out_go && emit)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            x     <= s_tdata[31:0];
            stamp <= s_tdata[79:32];
            cnt   <= '0;
            sum   <= '0;
            p1    <= 1'b0;
            if (fill_count < len) begin
              fill_count <= fill_count + CW'(1);
              state      <= S_GAP;
            end else begin
              state <= S_SUM;
            end
          end
        end
        S_GAP: state <= S_IDLE;
        S_SUM: begin
          if (issue) cnt <= cnt + CW'(1);
          p1 <= issue;
          if (p1) sum <= sum + {{(SW-32){rdata[31]}}, rdata};
          if (!issue && !p1) begin
            // floor division of a negative sum: -(floor((|s|-1)/L) + 1)
            sum_neg <= sum[SW-1];
            div_n   <= {(sum[SW-1] ? ~sum : sum), {(DW-SW){1'b0}}};
            div_d   <= 32'(len);
            div_r   <= '0;
            div_cnt <= DCW'(SW);
            state   <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (div_cnt != '0) begin
            div_r   <= div_ge ? div_sub[31:0] : div_r2[31:0];
            div_n   <= {div_n[DW-2:0], div_ge};
            div_cnt <= div_cnt - DCW'(1);
          end else begin
            mean  <= sum_neg ? ~div_n[31:0] : div_n[31:0];
            cnt   <= '0;
            acc   <= '0;
            p1    <= 1'b0;
            p2    <= 1'b0;
            p3    <= 1'b0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (issue) cnt <= cnt + CW'(1);
          p1 <= issue;
          p2 <= p1;
          p3 <= p2;
          if (p1) ad <= ad_n;
          if (p2) sq <= sq_n;
          if (p3) acc <= acc + {{CW{1'b0}}, sq};
          if (!issue && !p1 && !p2 && !p3) begin
            div_n   <= acc;
            div_d   <= 32'(len - CW'(1));
            div_r   <= '0;
            div_cnt <= DCW'(DW);
            state   <= S_VAR;
          end
        end
        S_VAR: begin
          if (div_cnt != '0) begin
            div_r   <= div_ge ? div_sub[31:0] : div_r2[31:0];
            div_n   <= {div_n[DW-2:0], div_ge};
            div_cnt <= div_cnt - DCW'(1);
          end else begin
            sq_src  <= var_sat;
            sq_rem  <= '0;
            sq_root <= '0;
            sq_cnt  <= 6'd32;
            state   <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_cnt != 6'd0) begin
            sq_src <= {sq_src[61:0], 2'b00};
            if (sq_remn >= sq_trial) begin
              sq_rem  <= sq_remn - sq_trial;
              sq_root <= {sq_root[30:0], 1'b1};
            end else begin
              sq_rem  <= sq_remn;
              sq_root <= {sq_root[30:0], 1'b0};
            end
            sq_cnt <= sq_cnt - 6'd1;
          end else begin
            if (sq_root < {1'b0, min_std_dev}) begin
              emit  <= 1'b0;
              state <= S_OUT;
            end else if (sq_root == 32'd0) begin
              // zero deviation with a zero floor: saturate unless the gap is zero
              zmag  <= ZW'(24'h800000);
              emit  <= 1'b0;
              state <= (mag == 33'd0) ? S_OUT : S_EVAL;
            end else begin
              div_n   <= {mag, 12'd0, {(DW-ZW){1'b0}}};
              div_d   <= sq_root;
              div_r   <= '0;
              div_cnt <= DCW'(ZW);
              state   <= S_ZDIV;
            end
          end
        end
        S_ZDIV: begin
          if (div_cnt != '0) begin
            div_r   <= div_ge ? div_sub[31:0] : div_r2[31:0];
            div_n   <= {div_n[DW-2:0], div_ge};
            div_cnt <= div_cnt - DCW'(1);
          end else begin
            zmag  <= div_n[ZW-1:0];
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          emit   <= crit | warn;
          ev_sev <= crit;
          ev_z   <= zraw;
          state  <= S_OUT;
        end
        S_OUT: begin
          if (out_go) begin
            if (emit) begin
              m_tvalid <= 1'b1;
              o_sev    <= ev_sev;
              o_z      <= ev_z;
              o_val    <= x;
              o_stamp  <= stamp;
            end
            if (CW'(oldest_pointer) == len - CW'(1)) begin
              oldest_pointer <= '0;
            end else begin
              oldest_pointer <= oldest_pointer + AW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cfg_we) begin
        case (cfg_idx)
          rzad_pkg::REG_WARMUP_LENGTH: begin
            warmup_length  <= pwdata[6:0];
            fill_count     <= '0;
            oldest_pointer <= '0;
          end
          rzad_pkg::REG_MIN_STD_DEV:   min_std_dev   <= pwdata[30:0];
          rzad_pkg::REG_MIN_ABS_DELTA: min_abs_delta <= pwdata[30:0];
          rzad_pkg::REG_WARNING_Z:     warning_z     <= pwdata[15:0];
          rzad_pkg::REG_CRITICAL_Z:    critical_z    <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/rzad_checker.sv
// Port-level checks for the z-score detector, bound to the top level.
`default_nettype none
`include "rolling_zscore_anomaly_detector_macros.svh"
module rzad_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [rzad_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic                           m_tuser
);

  // an accepted request always leaves the sequencer busy in the next cycle
  `RZAD_ASSERT(a_busy_after_req, clk, rst, (s_tvalid && s_tready) |=> !s_tready)
  `RZAD_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid)
  `RZAD_ASSERT(a_hold_valid, clk, rst, (m_tvalid && !m_tready) |=> m_tvalid)
  `RZAD_ASSERT(a_hold_data, clk, rst, (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))

endmodule

bind rolling_zscore_anomaly_detector rzad_checker u_rzad_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire

>>> tb/rolling_zscore_anomaly_detector_tb.sv
// Testbench for the rolling z-score detector: directed and random samples, scored by a local model.
`default_nettype none
module rolling_zscore_anomaly_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  SETTLE_CYCLES = 600;
  localparam int  HOLD_CYCLES   = 3000;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic        severity;
    logic [31:0] value;
    logic [23:0] z;
    logic [47:0] stamp;
  } anomaly_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [rzad_pkg::S_TDATA_W-1:0] s_tdata = '0;   // sample_value[31:0], stamp_in[79:32]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [rzad_pkg::M_TDATA_W-1:0] m_tdata;        // event_value[31:0], z_score[55:32], stamp_out[103:56]
  logic m_tuser;                                  // event_severity[0]
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [rzad_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rolling_zscore_anomaly_detector uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // local copy of the detector state
  logic [31:0] win_samples [64];
  int unsigned fill_cnt = 0;
  int unsigned oldest_idx = 0;
  logic [6:0]  cfg_len = rzad_pkg::RST_WARMUP_LENGTH;
  logic [30:0] cfg_min_sd = rzad_pkg::RST_MIN_STD_DEV;
  logic [30:0] cfg_min_gap = rzad_pkg::RST_MIN_ABS_DELTA;
  logic [15:0] cfg_warn = rzad_pkg::RST_WARNING_Z;
  logic [15:0] cfg_crit = rzad_pkg::RST_CRITICAL_Z;

  anomaly_t pending_events [$];
  int  mismatches = 0;
  bit  hold_req = 1'b0;
  bit  quiet = 1'b0;
  longint cycles = 0;

  function automatic int unsigned window_len();
    if (cfg_len < 2) return 2;
    if (cfg_len > 64) return 64;
    return 32'(cfg_len);
  endfunction

  function automatic void push_window(logic [31:0] x, int unsigned len);
    win_samples[oldest_idx] = x;
    oldest_idx = (oldest_idx + 1) % len;
  endfunction

  // returns 1 when the sample raises an event
  function automatic bit score_sample(input logic [31:0] x, input logic [47:0] st,
                                      output anomaly_t ev);
    int unsigned len;
    longint sum, mean, d, delta;
    logic [127:0] sq_acc, quot;
    logic [63:0] variance, sd, ad, mag, zmag, rest, res, bitv;
    bit neg, far, crit, warn;
    len = window_len();
    ev = '0;
    if (fill_cnt < len) begin
      win_samples[fill_cnt] = x;
      fill_cnt++;
      return 0;
    end
    sum = 0;
    for (int i = 0; i < len; i++) sum += longint'($signed(win_samples[i]));
    mean = sum / longint'(len);
    if (sum % longint'(len) != 0 && sum < 0) mean--;
    sq_acc = '0;
    for (int i = 0; i < len; i++) begin
      d = longint'($signed(win_samples[i])) - mean;
      ad = d < 0 ? -d : d;
      sq_acc += 128'(ad) * 128'(ad);
    end
    quot = sq_acc / 128'(len - 1);
    variance = (quot[127:64] != 0) ? '1 : quot[63:0];
    // bitwise integer root
    rest = variance;
    res = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rest) bitv >>= 2;
    while (bitv != 0) begin
      if (rest >= res + bitv) begin
        rest -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    sd = res;
    if (sd < 64'(cfg_min_sd)) begin
      push_window(x, len);
      return 0;
    end
    delta = longint'($signed(x)) - mean;
    neg = delta < 0;
    mag = neg ? -delta : delta;
    if (sd == 0) begin
      if (mag == 0) begin
        push_window(x, len);
        return 0;
      end
      zmag = 64'd8388608;
    end else begin
      zmag = (mag << 12) / sd;
    end
    far  = mag >= 64'(cfg_min_gap);
    crit = far && zmag >= {44'd0, cfg_crit, 4'd0};
    warn = far && zmag >= {44'd0, cfg_warn, 4'd0};
    if (neg) begin
      if (zmag > 64'd8388608) zmag = 64'd8388608;
      ev.z = -zmag[23:0];
    end else begin
      if (zmag > 64'd8388607) zmag = 64'd8388607;
      ev.z = zmag[23:0];
    end
    push_window(x, len);
    if (!crit && !warn) return 0;
    ev.severity = crit;
    ev.value = x;
    ev.stamp = st;
    return 1;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    anomaly_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[31:0], m_tdata[55:32], m_tdata[103:56]};
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected event %h", got);
      end else begin
        want = pending_events[0];
        pending_events.delete(0);
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("event mismatch: sev %b/%b value %h/%h z %h/%h stamp %h/%h",
                     want.severity, got.severity, want.value, got.value,
                     want.z, got.z, want.stamp, got.stamp);
        end
      end
    end
  end

  // receiver: random stalls, and one long hold-off on request
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [31:0] x, input logic [47:0] st);
    anomaly_t ev;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {st, x};
    do @(posedge clk); while (!s_tready);
    if (score_sample(x, st, ev)) pending_events = {pending_events, ev};
  endtask

  // lower the request and let the block drain before anything else happens
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending_events.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= rzad_pkg::PADDR_W'(idx) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      rzad_pkg::REG_WARMUP_LENGTH: begin
        cfg_len = v[6:0];
        fill_cnt = 0;
        oldest_idx = 0;
      end
      rzad_pkg::REG_MIN_STD_DEV:   cfg_min_sd = v[30:0];
      rzad_pkg::REG_MIN_ABS_DELTA: cfg_min_gap = v[30:0];
      rzad_pkg::REG_WARNING_Z:     cfg_warn = v[15:0];
      rzad_pkg::REG_CRITICAL_Z:    cfg_crit = v[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [47:0] rand_stamp();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  function automatic logic [31:0] rand_sample(longint base, int unsigned amp_sh);
    longint v;
    case ($urandom_range(0, 19))
      0: return $urandom();
      1, 2, 3: v = base + longint'($signed($urandom())) % (longint'(1) << amp_sh)
                   * longint'($urandom_range(3, 30));
      default: v = base + longint'($signed($urandom())) % (longint'(1) << amp_sh);
    endcase
    if (v > 64'sh7fff_ffff) v = 64'sh7fff_ffff;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return v[31:0];
  endfunction

  // constant window with a zero floor, then gaps of zero, negative and positive
  task automatic test_zero_deviation();
    write_reg(rzad_pkg::REG_WARMUP_LENGTH, 2);
    write_reg(rzad_pkg::REG_MIN_STD_DEV, 0);
    send_sample(32'h0001_0000, 48'h0);
    send_sample(32'h0001_0000, 48'hFFFF_FFFF_FFFF);
    send_sample(32'h0001_0000, 48'h1);
    send_sample(32'h8000_0000, 48'h8000_0000_0000);
    send_sample(32'h8000_0000, 48'h5555_5555_5555);
    send_sample(32'h8000_0000, 48'hAAAA_AAAA_AAAA);
    send_sample(32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF);
    send_sample(32'hFFFF_FFFF, 48'h0000_0000_0001);
    drain();
  endtask

  // lengths below the minimum clamp to two; rewriting the same length clears the window
  task automatic test_length_rewrite();
    write_reg(rzad_pkg::REG_MIN_STD_DEV, 1);
    write_reg(rzad_pkg::REG_WARMUP_LENGTH, 0);
    send_sample(32'h0000_0000, rand_stamp());
    send_sample(32'h0004_0000, rand_stamp());
    send_sample(32'h0100_0000, rand_stamp());
    drain();
    write_reg(rzad_pkg::REG_WARMUP_LENGTH, 1);
    send_sample(32'h0002_0000, rand_stamp());
    send_sample(32'hFFFE_0000, rand_stamp());
    send_sample(32'h0040_0000, rand_stamp());
    drain();
    write_reg(rzad_pkg::REG_WARMUP_LENGTH, 3);
    send_sample(32'h0001_0000, rand_stamp());
    send_sample(32'h0003_0000, rand_stamp());
    drain();
    write_reg(rzad_pkg::REG_WARMUP_LENGTH, 3);
    send_sample(32'h0001_0000, rand_stamp());
    send_sample(32'h0002_0000, rand_stamp());
    send_sample(32'h0003_0000, rand_stamp());
    send_sample(32'hF000_0000, rand_stamp());
    drain();
  endtask

  // oversized length clamps to 64; the window alternates between the extreme sample values
  task automatic test_huge_variance();
    write_reg(rzad_pkg::REG_WARMUP_LENGTH, 127);
    write_reg(rzad_pkg::REG_MIN_STD_DEV, 0);
    write_reg(rzad_pkg::REG_WARNING_Z, 0);
    write_reg(rzad_pkg::REG_CRITICAL_Z, 32'h0000_FFFF);
    for (int i = 0; i < 64; i++)
      send_sample(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000, rand_stamp());
    send_sample(32'h7FFF_FFFF, rand_stamp());
    send_sample(32'h8000_0000, rand_stamp());
    drain();
  endtask

  task automatic test_random(input int phases, input int per_phase);
    int unsigned len, amp;
    longint base;
    for (int p = 0; p < phases; p++) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 64) : $urandom_range(2, 10);
      write_reg(rzad_pkg::REG_WARMUP_LENGTH, len);
      case ($urandom_range(0, 4))
        0: write_reg(rzad_pkg::REG_MIN_STD_DEV, 0);
        1: write_reg(rzad_pkg::REG_MIN_STD_DEV, 32'h7FFF_FFFF);
        default: write_reg(rzad_pkg::REG_MIN_STD_DEV, $urandom_range(0, 32'h0004_0000));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(rzad_pkg::REG_MIN_ABS_DELTA, 32'h7FFF_FFFF);
        1: write_reg(rzad_pkg::REG_MIN_ABS_DELTA, $urandom());
        default: write_reg(rzad_pkg::REG_MIN_ABS_DELTA, $urandom_range(0, 32'h0010_0000));
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(rzad_pkg::REG_WARNING_Z, 0);
        1: write_reg(rzad_pkg::REG_WARNING_Z, 32'h0000_FFFF);
        default: write_reg(rzad_pkg::REG_WARNING_Z, $urandom_range(128, 1024));
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(rzad_pkg::REG_CRITICAL_Z, 0);
        1: write_reg(rzad_pkg::REG_CRITICAL_Z, 32'h0000_FFFF);
        default: write_reg(rzad_pkg::REG_CRITICAL_Z, $urandom_range(512, 2048));
      endcase
      base = longint'($signed($urandom()));
      amp = $urandom_range(4, 28);
      for (int i = 0; i < per_phase; i++) send_sample(rand_sample(base, amp), rand_stamp());
      drain();
    end
  endtask

  // output held off with zero warning and gap thresholds, so evaluated samples raise events and the input backs up
  task automatic test_backpressure();
    write_reg(rzad_pkg::REG_WARMUP_LENGTH, 2);
    write_reg(rzad_pkg::REG_MIN_STD_DEV, 0);
    write_reg(rzad_pkg::REG_MIN_ABS_DELTA, 0);
    write_reg(rzad_pkg::REG_WARNING_Z, 0);
    write_reg(rzad_pkg::REG_CRITICAL_Z, 1024);
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_sample($urandom(), rand_stamp());
    s_tvalid <= 1'b0;
    @(posedge clk);
    // sender pause until all events are out
    wait (pending_events.size() == 0);
    for (int i = 0; i < 10; i++) send_sample($urandom(), rand_stamp());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_deviation();
    test_length_rewrite();
    test_huge_variance();
    test_backpressure();
    test_random(10, 105);
    quiet = 1'b1;
    test_random(1, 150);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/rzad_pkg.sv
rtl/rolling_zscore_anomaly_detector.sv
rtl/rzad_checker.sv
tb/rolling_zscore_anomaly_detector_tb.sv
